// File: design/bwts_pkg.sv
// Shared types, constants and arithmetic helpers for the bilinear wrap texel sampler.
// No dependencies; bwts_front, bwts_back and the top level import this package.
`timescale 1ns / 1ps

package bwts_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_SIZE_LOG2_DEF = 8;
  localparam int NUM_MAPS_DEF      = 2;

  // Size register after reset
  localparam logic [3:0] SIZE_LOG2_RESET = 4'd8;

  // Buffering between and behind the two halves
  localparam int QUEUE_DEPTH = 4;
  localparam int OUT_DEPTH   = 8;

  // Texel layout: three Q7.8 channels, first channel in the low bits
  localparam int CHAN_W    = 16;
  localparam int NUM_CHAN  = 3;
  localparam int TEXEL_W   = CHAN_W * NUM_CHAN;
  localparam int FRAC_W    = 16;
  localparam int NUM_BANKS = 4;

  // What a queued item asks of the back end
  typedef enum logic [1:0] {
    KIND_WRITE  = 2'b00,
    KIND_SAMPLE = 2'b01,
    KIND_ZERO   = 2'b10
  } kind_t;

  // Fixed-width part of a queue entry
  typedef struct packed {
    kind_t                kind;
    logic [1:0]           wbank;  // {row parity, column parity} of a written texel
    logic                 sx;     // parity of the left sample column
    logic                 sy;     // parity of the top sample row
    logic [FRAC_W-1:0]    tx;
    logic [FRAC_W-1:0]    ty;
    logic [TEXEL_W-1:0]   wdata;
  } entry_ctl_t;

  // Entries per parity bank: a quarter of each map, for every map
  function automatic int bank_depth(input int max_lg, input int maps);
    return maps << (2 * (max_lg - 1));
  endfunction

  function automatic int addr_bits(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

  // Lerp step one: difference times weight
  function automatic logic signed [33:0] lerp_mul(input logic signed [16:0] d,
                                                  input logic [FRAC_W-1:0] t);
    logic signed [16:0] ts;
    ts = $signed({1'b0, t});
    return 34'(d) * 34'(ts);
  endfunction

  // Lerp step two: round to Q7.8 (ties upward) and add the base operand
  function automatic logic signed [CHAN_W-1:0] lerp_fin(input logic signed [CHAN_W-1:0] a,
                                                        input logic signed [33:0] p);
    logic signed [33:0] s;
    logic signed [17:0] q;
    logic signed [17:0] r;
    s = p + 34'sd32768;
    q = s[33:16];
    r = 18'(a) + q;
    return r[CHAN_W-1:0];
  endfunction

endpackage

// File: design/bwts_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bwts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable, read every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/bwts_fifo.sv
// Small register FIFO used for the front-to-back queue and the result buffer.
// No dependencies.
`timescale 1ns / 1ps

module bwts_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  // Store pushed item
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

endmodule

// File: design/bwts_front.sv
// Front end: accepts items, holds the size register, classifies each item and
// works out bank addresses, parities and fractions. Depends on bwts_pkg.
`timescale 1ns / 1ps

module bwts_front #(
  parameter int MAX_SIZE_LOG2 = bwts_pkg::MAX_SIZE_LOG2_DEF,
  parameter int NUM_MAPS      = bwts_pkg::NUM_MAPS_DEF,
  parameter int ABITS         = bwts_pkg::addr_bits(bwts_pkg::bank_depth(MAX_SIZE_LOG2,
                                                                         NUM_MAPS))
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [3:0]                            cfg_wdata,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [127:0]                          s_tdata,
  input  logic [1:0]                            s_tuser,
  input  logic                                  q_full,
  output logic                                  q_push,
  output bwts_pkg::entry_ctl_t                  q_ctl,
  output logic [ABITS-1:0]                      q_waddr,
  output logic [bwts_pkg::NUM_BANKS-1:0][ABITS-1:0] q_raddr
);

  import bwts_pkg::*;

  localparam int CW  = FRAC_W + MAX_SIZE_LOG2;
  localparam int LGW = $clog2(MAX_SIZE_LOG2 + 1);

  logic [3:0]               size_log2;
  logic [LGW-1:0]           lg;
  logic [MAX_SIZE_LOG2-1:0] mask;
  logic                     action;
  logic                     cascade;
  logic                     bad_map;
  logic [MAX_SIZE_LOG2-1:0] col_m;
  logic [MAX_SIZE_LOG2-1:0] row_m;
  logic [31:0]              coord [2];
  logic [CW-1:0]            scaled [2];
  logic [CW-1:0]            pos [2];
  logic [MAX_SIZE_LOG2-1:0] whole [2];
  logic [MAX_SIZE_LOG2-1:0] i0 [2];
  logic [MAX_SIZE_LOG2-1:0] i1 [2];
  logic [FRAC_W-1:0]        frac [2];
  logic [MAX_SIZE_LOG2-1:0] rsel;
  logic [MAX_SIZE_LOG2-1:0] csel;

  // Entry address inside a parity bank: {map, row / 2, column / 2}
  function automatic logic [ABITS-1:0] bank_addr(input logic m,
                                                 input logic [MAX_SIZE_LOG2-1:0] r,
                                                 input logic [MAX_SIZE_LOG2-1:0] c);
    logic [31:0] a;
    a = (32'(m) << (2 * (MAX_SIZE_LOG2 - 1)))
      | ((32'(r) >> 1) << (MAX_SIZE_LOG2 - 1))
      | (32'(c) >> 1);
    return ABITS'(a);
  endfunction

  // Hold the size register
  always_ff @(posedge clk) begin
    if (rst) begin
      size_log2 <= SIZE_LOG2_RESET;
    end else if (cfg_we) begin
      size_log2 <= cfg_wdata;
    end
  end

  // Saturate the size to the supported range
  always_comb begin
    if (size_log2 == 4'd0) begin
      lg = LGW'(1);
    end else if (32'(size_log2) > MAX_SIZE_LOG2) begin
      lg = LGW'(MAX_SIZE_LOG2);
    end else begin
      lg = LGW'(size_log2);
    end
  end

  assign mask    = MAX_SIZE_LOG2'((32'd1 << lg) - 32'd1);
  assign action  = s_tuser[0];
  assign cascade = s_tuser[1];
  assign bad_map = (32'(cascade) >= NUM_MAPS);
  assign col_m   = MAX_SIZE_LOG2'(s_tdata[7:0]);
  assign row_m   = MAX_SIZE_LOG2'(s_tdata[15:8]);
  assign coord[0] = s_tdata[95:64];
  assign coord[1] = s_tdata[127:96];

  // Scale, shift by half a texel, split into wrapped indices and fraction
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      scaled[k] = coord[k][CW-1:0] << lg;
      pos[k]    = scaled[k] - CW'(32'd32768);
      whole[k]  = pos[k][CW-1:FRAC_W];
      i0[k]     = whole[k] & mask;
      i1[k]     = (whole[k] + MAX_SIZE_LOG2'(1)) & mask;
      frac[k]   = pos[k][FRAC_W-1:0];
    end
  end

  // Route each neighbour to the bank of its row and column parity
  always_comb begin
    rsel = '0;
    csel = '0;
    for (int b = 0; b < NUM_BANKS; b++) begin
      rsel = (i0[1][0] == 1'(b >> 1)) ? i0[1] : i1[1];
      csel = (i0[0][0] == 1'(b)) ? i0[0] : i1[0];
      q_raddr[b] = bank_addr(cascade, rsel, csel);
    end
  end

  // Classify the item
  always_comb begin
    q_ctl.wbank = {row_m[0], col_m[0]};
    q_ctl.sx    = i0[0][0];
    q_ctl.sy    = i0[1][0];
    q_ctl.tx    = frac[0];
    q_ctl.ty    = frac[1];
    q_ctl.wdata = s_tdata[63:16];
    if (!action) begin
      q_ctl.kind = KIND_WRITE;
    end else if (bad_map) begin
      q_ctl.kind = KIND_ZERO;
    end else begin
      q_ctl.kind = KIND_SAMPLE;
    end
  end

  assign q_waddr  = bank_addr(cascade, row_m, col_m);
  assign s_tready = !q_full;
  // Drop writes to a missing map without queueing them
  assign q_push   = s_tvalid && s_tready && !(!action && bad_map);

endmodule

// File: design/bwts_back.sv
// Back end: issues texel writes and four-bank reads, runs the x and y lerps in a
// six-stage pipeline and buffers results. Depends on bwts_pkg, bwts_ram, bwts_fifo.
`timescale 1ns / 1ps

module bwts_back #(
  parameter int MAX_SIZE_LOG2 = bwts_pkg::MAX_SIZE_LOG2_DEF,
  parameter int NUM_MAPS      = bwts_pkg::NUM_MAPS_DEF,
  parameter int ABITS         = bwts_pkg::addr_bits(bwts_pkg::bank_depth(MAX_SIZE_LOG2,
                                                                         NUM_MAPS))
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      q_empty,
  output logic                                      q_pop,
  input  bwts_pkg::entry_ctl_t                      q_ctl,
  input  logic [ABITS-1:0]                          q_waddr,
  input  logic [bwts_pkg::NUM_BANKS-1:0][ABITS-1:0] q_raddr,
  output logic                                      m_tvalid,
  input  logic                                      m_tready,
  output logic [bwts_pkg::TEXEL_W-1:0]              m_tdata
);

  import bwts_pkg::*;

  localparam int BANK_DEPTH = bank_depth(MAX_SIZE_LOG2, NUM_MAPS);
  localparam int OCW        = $clog2(OUT_DEPTH + 1);

  logic [OCW-1:0]          occ;
  logic                    is_write;
  logic                    occ_inc;
  logic                    out_pop;
  logic                    out_empty;
  logic [NUM_BANKS-1:0]    bank_we;
  logic [TEXEL_W-1:0]      rdata [NUM_BANKS];

  logic                    v1, v2, v3, v4, v5, v6;
  logic                    z1, z2, z3, z4, z5, z6;
  logic                    sx1, sy1;
  logic [FRAC_W-1:0]       tx1, tx2;
  logic [FRAC_W-1:0]       ty1, ty2, ty3, ty4, ty5;
  logic [TEXEL_W-1:0]      p00, p10, p01, p11;
  logic signed [CHAN_W-1:0] a2 [NUM_CHAN][2];
  logic signed [16:0]       d2 [NUM_CHAN][2];
  logic signed [CHAN_W-1:0] a3 [NUM_CHAN][2];
  logic signed [33:0]       prod3 [NUM_CHAN][2];
  logic signed [CHAN_W-1:0] top4 [NUM_CHAN];
  logic signed [CHAN_W-1:0] bot4 [NUM_CHAN];
  logic signed [CHAN_W-1:0] a5 [NUM_CHAN];
  logic signed [16:0]       d5 [NUM_CHAN];
  logic signed [CHAN_W-1:0] a6 [NUM_CHAN];
  logic signed [33:0]       prod6 [NUM_CHAN];
  logic [TEXEL_W-1:0]       res;

  // Issue: writes always go, result items need room in the result buffer
  assign is_write = (q_ctl.kind == KIND_WRITE);
  assign q_pop    = !q_empty && (is_write || (occ < OCW'(OUT_DEPTH)));
  assign occ_inc  = q_pop && !is_write;
  assign out_pop  = m_tvalid && m_tready;

  // Count result items in flight or buffered
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ + OCW'(occ_inc) - OCW'(out_pop);
    end
  end

  // Parity banks: the four neighbours always fall in different banks
  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    assign bank_we[b] = q_pop && is_write && (q_ctl.wbank == 2'(b));
    bwts_ram #(
      .WIDTH (TEXEL_W),
      .DEPTH (BANK_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (bank_we[b]),
      .waddr (q_waddr),
      .wdata (q_ctl.wdata),
      .raddr (q_raddr[b]),
      .rdata (rdata[b])
    );
  end

  // Advance stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      v1 <= occ_inc;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  // Put the bank outputs back in neighbour order
  always_comb begin
    p00 = rdata[{sy1, sx1}];
    p10 = rdata[{sy1, ~sx1}];
    p01 = rdata[{~sy1, sx1}];
    p11 = rdata[{~sy1, ~sx1}];
  end

  // Pipeline payload: x lerps over stages two to four, y lerp over five and six
  always_ff @(posedge clk) begin
    z1  <= (q_ctl.kind == KIND_ZERO);
    sx1 <= q_ctl.sx;
    sy1 <= q_ctl.sy;
    tx1 <= q_ctl.tx;
    ty1 <= q_ctl.ty;

    z2  <= z1;
    tx2 <= tx1;
    ty2 <= ty1;
    z3  <= z2;
    ty3 <= ty2;
    z4  <= z3;
    ty4 <= ty3;
    z5  <= z4;
    ty5 <= ty4;
    z6  <= z5;

    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      a2[ch][0] <= p00[ch*CHAN_W +: CHAN_W];
      a2[ch][1] <= p01[ch*CHAN_W +: CHAN_W];
      d2[ch][0] <= 17'($signed(p10[ch*CHAN_W +: CHAN_W]))
                 - 17'($signed(p00[ch*CHAN_W +: CHAN_W]));
      d2[ch][1] <= 17'($signed(p11[ch*CHAN_W +: CHAN_W]))
                 - 17'($signed(p01[ch*CHAN_W +: CHAN_W]));
      for (int j = 0; j < 2; j++) begin
        a3[ch][j]    <= a2[ch][j];
        prod3[ch][j] <= lerp_mul(d2[ch][j], tx2);
      end
      top4[ch]  <= lerp_fin(a3[ch][0], prod3[ch][0]);
      bot4[ch]  <= lerp_fin(a3[ch][1], prod3[ch][1]);
      a5[ch]    <= top4[ch];
      d5[ch]    <= 17'(bot4[ch]) - 17'(top4[ch]);
      a6[ch]    <= a5[ch];
      prod6[ch] <= lerp_mul(d5[ch], ty5);
    end
  end

  // Finish the y lerp; a sample of a missing map gives zero
  always_comb begin
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      res[ch*CHAN_W +: CHAN_W] = z6 ? '0 : lerp_fin(a6[ch], prod6[ch]);
    end
  end

  // Result buffer parts the pipeline from the output handshake
  bwts_fifo #(
    .WIDTH (TEXEL_W),
    .DEPTH (OUT_DEPTH)
  ) u_out (
    .clk   (clk),
    .rst   (rst),
    .push  (v6),
    .wdata (res),
    .full  (),
    .pop   (out_pop),
    .rdata (m_tdata),
    .empty (out_empty)
  );

  assign m_tvalid = !out_empty;

endmodule

// File: design/bilinear_wrap_texel_sampler_unit.sv
// Top level of the bilinear wrap texel sampler: front end, entry queue, back end.
// Depends on bwts_pkg, bwts_front, bwts_fifo, bwts_back.
`timescale 1ns / 1ps

// Bilinear texture sampler with wrap addressing over NUM_MAPS square maps of
// three Q7.8 channels. An item with tuser action 0 writes one texel; action 1
// returns one filtered sample (zero when the map does not exist). The block
// takes one item per clock in steady state, writes and samples alike, mixed in
// any order, while samples find room in the result buffer; a sample reads
// every texel written by earlier items. The rate is set by the texel store,
// split into four banks by row and column parity so that the four neighbours
// of a sample are read in the same cycle. A sample result passes the entry
// queue and bank read, the lerp pipeline and the result buffer before it is
// offered. The user must write the size register through cfg_we / cfg_wdata
// only while the block is idle; the block itself does not enforce this.
// Texels read before they are written return undefined values.
module bilinear_wrap_texel_sampler_unit #(
  parameter int MAX_SIZE_LOG2 = bwts_pkg::MAX_SIZE_LOG2_DEF,
  parameter int NUM_MAPS      = bwts_pkg::NUM_MAPS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [3:0]   cfg_wdata,       // size_log2
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // texel_col[7:0], texel_row[15:8], texel_dx[31:16], texel_dy[47:32],
  // texel_dz[63:48], coord_u[95:64], coord_v[127:96]
  input  logic [127:0] s_axis_tdata,
  // action[0], cascade[1]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // sample_x[15:0], sample_y[31:16], sample_z[47:32]
  output logic [47:0]  m_axis_tdata
);

  import bwts_pkg::*;

  localparam int ABITS = addr_bits(bank_depth(MAX_SIZE_LOG2, NUM_MAPS));
  localparam int CTLW  = $bits(entry_ctl_t);
  localparam int QW    = CTLW + (NUM_BANKS + 1) * ABITS;

  entry_ctl_t                      f_ctl;
  logic [ABITS-1:0]                f_waddr;
  logic [NUM_BANKS-1:0][ABITS-1:0] f_raddr;
  logic                            q_push;
  logic                            q_full;
  logic                            q_pop;
  logic                            q_empty;
  logic [QW-1:0]                   q_wr;
  logic [QW-1:0]                   q_rd;
  entry_ctl_t                      b_ctl;
  logic [ABITS-1:0]                b_waddr;
  logic [NUM_BANKS-1:0][ABITS-1:0] b_raddr;

  // Accept and classify
  bwts_front #(
    .MAX_SIZE_LOG2 (MAX_SIZE_LOG2),
    .NUM_MAPS      (NUM_MAPS),
    .ABITS         (ABITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_axis_tvalid),
    .s_tready  (s_axis_tready),
    .s_tdata   (s_axis_tdata),
    .s_tuser   (s_axis_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_ctl     (f_ctl),
    .q_waddr   (f_waddr),
    .q_raddr   (f_raddr)
  );

  // Pack entries into the queue and unpack them on the far side
  assign q_wr    = {f_raddr, f_waddr, f_ctl};
  assign b_ctl   = entry_ctl_t'(q_rd[CTLW-1:0]);
  assign b_waddr = q_rd[CTLW +: ABITS];
  assign b_raddr = q_rd[CTLW + ABITS +: NUM_BANKS * ABITS];

  bwts_fifo #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wr),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rd),
    .empty (q_empty)
  );

  // Store texels and filter samples
  bwts_back #(
    .MAX_SIZE_LOG2 (MAX_SIZE_LOG2),
    .NUM_MAPS      (NUM_MAPS),
    .ABITS         (ABITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .q_ctl    (b_ctl),
    .q_waddr  (b_waddr),
    .q_raddr  (b_raddr),
    .m_tvalid (m_axis_tvalid),
    .m_tready (m_axis_tready),
    .m_tdata  (m_axis_tdata)
  );

endmodule
